// ===== hw/rtl/lwc_pkg.sv =====
`default_nettype none
package lwc_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int DISK_PAGES_DEF = 4096;
	localparam int ROW_W          = 16;
	localparam int ROW_SH         = 4;
	localparam int WGT_W          = 7;
	localparam int MD_W           = 4;
	localparam int WCAP_SH        = 2;
	localparam int CNT_W          = 32;
	localparam int CFG_IDX_W      = 1;
	localparam int CAP_RESET      = 64;
	localparam int MD_RESET       = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY = 1'b0,
		REG_MAX_DIST = 1'b1
	} lwc_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RES_RD,
		ST_RES_CHK,
		ST_LOC0,
		ST_LOC1,
		ST_LOC2,
		ST_LOC3,
		ST_HIT_UPD,
		ST_INS_BEGIN,
		ST_INS_OLD,
		ST_INS_CHK,
		ST_INS_SET,
		ST_INS_FIN,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_WALK_UPD,
		ST_RESULT
	} lwc_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/locality_weighted_clock_cache_core.sv =====
`default_nettype none
// a hit checks residency, scans neighbors and updates the weight; a fill miss first frees the
// old page of a used slot; a warm miss walks the clock hand, scanning neighbors until a full turn
// throughput: one transaction in flight; the result register frees the input early
// reset: bitmap clearing pass over DISK_PAGES/16 rows (256 at default) before the
// first transaction is taken; configuration writes are taken during the pass
module locality_weighted_clock_cache_core import lwc_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int DISK_PAGES = DISK_PAGES_DEF,
	localparam int SlotW = $clog2(SLOTS),
	localparam int PageW = $clog2(DISK_PAGES),
	localparam int CapW  = $clog2(SLOTS + 1),
	localparam int CfgW  = (CapW > MD_W) ? CapW : MD_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PageW-1:0]     page_id,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic      [SlotW-1:0]     slot,
	output logic                      evicted_valid,
	output logic      [PageW-1:0]     evicted_page,
	output logic                      warm,
	output logic      [CNT_W-1:0]     hit_count,
	output logic      [CNT_W-1:0]     miss_count,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CfgW-1:0]      cfg_data
);

	localparam int Rows   = (DISK_PAGES + ROW_W - 1) / ROW_W;
	localparam int RowAW  = (Rows > 1) ? $clog2(Rows) : 1;
	localparam int CapRst = (SLOTS < CAP_RESET) ? SLOTS : CAP_RESET;

	lwc_state_t state_q, state_d, ret_q;

	logic [CapW-1:0]  cap_q, c_eff, filled_q, turn_q;
	logic [MD_W-1:0]  md_q, md_eff, d_q, loc_d;
	logic [SlotW-1:0] hand_q, hand_eff, s_q, sn;
	logic [SLOTS-1:0] slot_valid_q;
	logic [CNT_W-1:0] hits_q, misses_q;
	logic [PageW-1:0] p_q, p_mod, loc_p_q, old_q;
	logic             warm_q, full_q, r_hit_q, r_ev_q;
	logic [PageW-1:0] r_evp_q;
	logic [ROW_W-1:0] prev_q, cur_q, next_row;
	logic [3*ROW_W-1:0] win;
	logic [2*ROW_W-2:0] sh;
	logic             accept, out_free, resident, old_hit, walk_pos, loc_found;
	logic [RowAW-1:0] loc_row;
	logic [7:0]       nw_hit, nw_walk, wcap;

	logic             bm_re, bm_we, bm_busy;
	logic [RowAW-1:0] bm_raddr, bm_waddr;
	logic [ROW_W-1:0] bm_rdata, bm_wdata;
	logic             ps_re, ps_we, sp_re, sp_we, wg_re, wg_we;
	logic [PageW-1:0] ps_raddr, ps_waddr, sp_rdata, sp_wdata;
	logic [SlotW-1:0] ps_rdata, ps_wdata, sp_raddr, sp_waddr, wg_raddr, wg_waddr;
	logic [WGT_W-1:0] wg_rdata, wg_wdata;

	lwc_bitmap #(.ROWS(Rows)) u_bitmap (
		.clk(clk), .arst_n(arst_n),
		.re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata),
		.we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.busy(bm_busy)
	);

	lwc_ram #(.W(SlotW), .D(DISK_PAGES)) u_page_slot (
		.clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
		.re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
	);

	lwc_ram #(.W(PageW), .D(SLOTS)) u_slot_page (
		.clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
		.re(sp_re), .raddr(sp_raddr), .rdata(sp_rdata)
	);

	lwc_ram #(.W(WGT_W), .D(SLOTS)) u_slot_weight (
		.clk(clk), .we(wg_we), .waddr(wg_waddr), .wdata(wg_wdata),
		.re(wg_re), .raddr(wg_raddr), .rdata(wg_rdata)
	);

	always_comb begin
		c_eff = cap_q;
		if (cap_q == '0) begin
			c_eff = CapW'(1);
		end else if (int'(cap_q) > SLOTS) begin
			c_eff = CapW'(SLOTS);
		end
	end

	assign md_eff   = (md_q == '0) ? MD_W'(1) : md_q;
	assign hand_eff = (CapW'(hand_q) >= c_eff) ? '0 : hand_q;
	assign sn       = (CapW'(s_q) + CapW'(1) == c_eff) ? '0 : s_q + 1'b1;
	assign p_mod    = (int'(page_id) >= DISK_PAGES) ? PageW'(int'(page_id) - DISK_PAGES)
	                                                : page_id;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !(state_q == ST_IDLE && !bm_busy);
	assign cfg_ready = 1'b1;

	assign resident = bm_rdata[p_q[ROW_SH-1:0]];
	assign old_hit  = bm_rdata[old_q[ROW_SH-1:0]] && (ps_rdata == s_q);
	assign wcap     = 8'(md_eff) << WCAP_SH;
	assign nw_hit   = {wg_rdata[WGT_W-1], wg_rdata} + 8'(md_eff) - 8'(d_q);
	assign nw_walk  = {wg_rdata[WGT_W-1], wg_rdata} - 8'(d_q);
	assign walk_pos = $signed(nw_walk) > 8'sd0;

	// nearest resident neighbor over a three-row window
	assign loc_row  = RowAW'(loc_p_q >> ROW_SH);
	assign next_row = (int'(loc_row) + 1 < Rows) ? bm_rdata : '0;
	assign win      = {next_row, cur_q, prev_q};
	assign sh       = (2*ROW_W-1)'(win >> (int'(loc_p_q[ROW_SH-1:0]) + 1));

	always_comb begin
		loc_d     = md_eff;
		loc_found = 1'b0;
		for (int k = 1; k < ROW_W; k++) begin
			if (!loc_found && (MD_W'(k) <= md_eff)
			    && (sh[ROW_W-1+k] || sh[ROW_W-1-k])) begin
				loc_d     = MD_W'(k);
				loc_found = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = ST_RES_RD;
			ST_RES_RD:    state_d = ST_RES_CHK;
			ST_RES_CHK: begin
				if (resident) state_d = ST_LOC0;
				else if (!warm_q) state_d = ST_INS_BEGIN;
				else if (slot_valid_q[hand_eff]) state_d = ST_WALK_RD;
				else state_d = ST_INS_BEGIN;
			end
			ST_LOC0:      state_d = ST_LOC1;
			ST_LOC1:      state_d = ST_LOC2;
			ST_LOC2:      state_d = ST_LOC3;
			ST_LOC3:      state_d = ret_q;
			ST_HIT_UPD:   state_d = ST_RESULT;
			ST_INS_BEGIN: state_d = slot_valid_q[s_q] ? ST_INS_OLD : ST_INS_SET;
			ST_INS_OLD:   state_d = ST_INS_CHK;
			ST_INS_CHK:   state_d = ST_INS_SET;
			ST_INS_SET:   state_d = ST_INS_FIN;
			ST_INS_FIN:   state_d = ST_RESULT;
			ST_WALK_RD:   state_d = ST_WALK_CHK;
			ST_WALK_CHK:  state_d = full_q ? ST_WALK_UPD : ST_LOC0;
			ST_WALK_UPD: begin
				if (!walk_pos) state_d = ST_INS_BEGIN;
				else if (slot_valid_q[sn]) state_d = ST_WALK_RD;
				else state_d = ST_INS_SET;
			end
			ST_RESULT:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		bm_re = 1'b0; bm_raddr = loc_row;
		bm_we = 1'b0; bm_waddr = RowAW'(p_q >> ROW_SH); bm_wdata = '0;
		ps_re = 1'b0; ps_raddr = p_q; ps_we = 1'b0; ps_waddr = p_q; ps_wdata = s_q;
		sp_re = 1'b0; sp_raddr = s_q; sp_we = 1'b0; sp_waddr = s_q; sp_wdata = p_q;
		wg_re = 1'b0; wg_raddr = s_q; wg_we = 1'b0; wg_waddr = s_q;
		wg_wdata = WGT_W'(md_eff);
		unique case (state_q)
			ST_RES_RD: begin
				bm_re    = 1'b1;
				bm_raddr = RowAW'(p_q >> ROW_SH);
				ps_re    = 1'b1;
			end
			ST_RES_CHK: begin
				wg_re    = resident;
				wg_raddr = ps_rdata;
			end
			ST_LOC0: begin
				bm_re    = 1'b1;
				bm_raddr = (loc_row == '0) ? loc_row : loc_row - 1'b1;
			end
			ST_LOC1: bm_re = 1'b1;
			ST_LOC2: begin
				bm_re    = 1'b1;
				bm_raddr = (int'(loc_row) + 1 < Rows) ? loc_row + 1'b1 : loc_row;
			end
			ST_HIT_UPD: begin
				wg_we    = $signed(nw_hit) <= $signed(wcap);
				wg_wdata = WGT_W'(nw_hit);
			end
			ST_INS_BEGIN: sp_re = slot_valid_q[s_q];
			ST_INS_OLD: begin
				bm_re    = 1'b1;
				bm_raddr = RowAW'(sp_rdata >> ROW_SH);
				ps_re    = 1'b1;
				ps_raddr = sp_rdata;
			end
			ST_INS_CHK: begin
				bm_we    = old_hit;
				bm_waddr = RowAW'(old_q >> ROW_SH);
				bm_wdata = bm_rdata & ~(ROW_W'(1) << old_q[ROW_SH-1:0]);
			end
			ST_INS_SET: begin
				bm_re    = 1'b1;
				bm_raddr = RowAW'(p_q >> ROW_SH);
				sp_we    = 1'b1;
				wg_we    = 1'b1;
				ps_we    = 1'b1;
			end
			ST_INS_FIN: begin
				bm_we    = 1'b1;
				bm_wdata = bm_rdata | (ROW_W'(1) << p_q[ROW_SH-1:0]);
			end
			ST_WALK_RD: begin
				sp_re = 1'b1;
				wg_re = 1'b1;
			end
			ST_WALK_UPD: begin
				wg_we    = 1'b1;
				wg_wdata = WGT_W'(nw_walk);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CapW'(CapRst);
			md_q         <= MD_W'(MD_RESET);
			hand_q       <= '0;
			filled_q     <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			slot_valid_q <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (lwc_reg_t'(cfg_index))
					REG_CAPACITY: cap_q <= cfg_data[CapW-1:0];
					REG_MAX_DIST: md_q  <= cfg_data[MD_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_RES_CHK && !resident && !warm_q) begin
				filled_q <= filled_q + 1'b1;
			end
			if (state_q == ST_HIT_UPD && warm_q) begin
				hits_q <= hits_q + 1'b1;
			end
			if (state_q == ST_INS_SET) begin
				slot_valid_q[s_q] <= 1'b1;
			end
			if (state_q == ST_INS_FIN) begin
				hand_q <= sn;
				if (warm_q) begin
					misses_q <= misses_q + 1'b1;
				end
			end
			if (state_q == ST_RESULT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					p_q     <= p_mod;
					warm_q  <= filled_q >= c_eff;
					r_hit_q <= 1'b0;
					r_ev_q  <= 1'b0;
					r_evp_q <= '0;
				end
			end
			ST_RES_CHK: begin
				if (resident) begin
					s_q     <= ps_rdata;
					r_hit_q <= 1'b1;
					loc_p_q <= p_q;
					ret_q   <= ST_HIT_UPD;
				end else begin
					s_q    <= hand_eff;
					turn_q <= '0;
					full_q <= 1'b0;
				end
			end
			ST_LOC1: prev_q <= (loc_row == '0) ? '0 : bm_rdata;
			ST_LOC2: cur_q  <= bm_rdata;
			ST_LOC3: d_q    <= loc_d;
			ST_INS_OLD: old_q <= sp_rdata;
			ST_INS_CHK: begin
				if (old_hit) begin
					r_ev_q  <= 1'b1;
					r_evp_q <= old_q;
				end
			end
			ST_WALK_CHK: begin
				if (full_q) begin
					d_q <= md_eff;
				end else begin
					loc_p_q <= sp_rdata;
					ret_q   <= ST_WALK_UPD;
				end
			end
			ST_WALK_UPD: begin
				if (walk_pos) begin
					s_q    <= sn;
					turn_q <= turn_q + 1'b1;
					if (turn_q + 1'b1 == c_eff) begin
						full_q <= 1'b1;
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					hit           <= r_hit_q;
					slot          <= s_q;
					evicted_valid <= r_ev_q;
					evicted_page  <= r_evp_q;
					warm          <= warm_q;
					hit_count     <= hits_q;
					miss_count    <= misses_q;
				end
			end
			default: ;
		endcase
	end

	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(filled_q) <= SLOTS)
		else $error("fill count past slot count");

	a_hand_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(hand_q) < SLOTS)
		else $error("clock hand out of range");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT |-> !(r_hit_q && r_ev_q))
		else $error("eviction reported on a hit");

	a_loc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HIT_UPD |-> d_q != '0 && d_q <= md_eff)
		else $error("locality distance out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/lwc_ram.sv =====
`default_nettype none
module lwc_ram #(
	parameter int W = 8,
	parameter int D = 64,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lwc_bitmap.sv =====
`default_nettype none
module lwc_bitmap import lwc_pkg::*; #(
	parameter int ROWS = 256,
	localparam int RowAW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             re,
	input  wire logic [RowAW-1:0] raddr,
	output logic      [ROW_W-1:0] rdata,
	input  wire logic             we,
	input  wire logic [RowAW-1:0] waddr,
	input  wire logic [ROW_W-1:0] wdata,
	output logic                  busy
);

	logic [ROW_W-1:0] mem [ROWS];
	logic [RowAW-1:0] clr_q;
	logic             busy_q;

	// clearing pass after reset, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (int'(clr_q) == ROWS - 1) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// ===== tb/locality_weighted_clock_cache_core_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module locality_weighted_clock_cache_core_test import lwc_pkg::*;;

	localparam int NSLOT  = 64;
	localparam int NPAGE  = 4096;
	localparam int LIMIT  = 20000000;

	typedef struct packed {
		logic        hit;
		logic [5:0]  slot;
		logic        evicted_valid;
		logic [11:0] evicted_page;
		logic        warm;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
	} access_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] page_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic [5:0]  slot;
	logic        evicted_valid;
	logic [11:0] evicted_page;
	logic        warm;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	lwc_reg_t    cfg_index = REG_CAPACITY;
	logic [6:0]  cfg_data = '0;

	// cache shadow
	bit          resident [NPAGE];
	logic [5:0]  page_slot [NPAGE];
	logic [11:0] slot_page [NSLOT];
	int          slot_weight [NSLOT];
	bit          slot_used [NSLOT];
	int unsigned hand, filled;
	logic [31:0] hits, misses;
	logic [6:0]  capacity;
	logic [3:0]  dist_range;

	access_t     pending_q [$];
	int          errors = 0;
	bit          no_idle = 1'b0;
	int unsigned cycles = 0;
	int unsigned window_base = 0;

	locality_weighted_clock_cache_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .page_id(page_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .slot(slot), .evicted_valid(evicted_valid), .evicted_page(evicted_page),
		.warm(warm), .hit_count(hit_count), .miss_count(miss_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 18);
	end

	function automatic int unsigned neighbor_gap(int unsigned p, int unsigned md);
		for (int unsigned k = 1; k <= md; k++) begin
			if (p + k < NPAGE && resident[p + k]) return k;
			if (p >= k && resident[p - k]) return k;
		end
		return md;
	endfunction

	function automatic void place_page(int unsigned s, int unsigned p, int unsigned md,
			inout access_t r);
		int unsigned old;
		if (slot_used[s]) begin
			old = slot_page[s];
			if (resident[old] && page_slot[old] == s) begin
				resident[old] = 1'b0;
				r.evicted_valid = 1'b1;
				r.evicted_page = 12'(old);
			end
		end
		slot_page[s] = 12'(p);
		slot_weight[s] = md;
		slot_used[s] = 1'b1;
		resident[p] = 1'b1;
		page_slot[p] = 6'(s);
		r.slot = 6'(s);
	endfunction

	function automatic access_t cache_lookup(logic [11:0] p);
		access_t r;
		int unsigned c, md, s, turn, sub;
		int nw;
		bit full_turn;
		c = (capacity < 1) ? 1 : (capacity > NSLOT) ? NSLOT : capacity;
		md = (dist_range == 0) ? 1 : dist_range;
		r = '0;
		r.warm = (filled >= c);
		if (resident[p]) begin
			s = page_slot[p];
			nw = slot_weight[s] + int'(md - neighbor_gap(p, md));
			if (r.warm) hits++;
			if (nw <= int'(4 * md)) slot_weight[s] = nw;
			r.hit = 1'b1;
			r.slot = 6'(s);
		end else begin
			if (hand >= c) hand = 0;
			if (!r.warm) begin
				filled++;
				place_page(hand, p, md, r);
				hand = (hand + 1) % c;
			end else begin
				s = hand;
				if (slot_used[s]) begin
					turn = 0;
					full_turn = 1'b0;
					slot_weight[s] -= int'(neighbor_gap(slot_page[s], md));
					while (slot_weight[s] > 0) begin
						s = (s + 1) % c;
						turn++;
						if (!slot_used[s]) break;
						if (full_turn || turn % c == 0) begin
							full_turn = 1'b1;
							sub = md;
						end else begin
							sub = neighbor_gap(slot_page[s], md);
						end
						slot_weight[s] -= int'(sub);
					end
				end
				place_page(s, p, md, r);
				hand = (s + 1) % c;
				misses++;
			end
		end
		r.hit_count = hits;
		r.miss_count = misses;
		return r;
	endfunction

	always @(posedge clk) begin
		access_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{hit, slot, evicted_valid, evicted_page, warm, hit_count, miss_count};
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, actual %p", $time, got);
			end else begin
				want = pending_q.pop_front();
				if (want.hit !== got.hit)
					$display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
				if (want.slot !== got.slot)
					$display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
				if (want.evicted_valid !== got.evicted_valid)
					$display("%0t: evicted_valid expected %0d actual %0d", $time,
						want.evicted_valid, got.evicted_valid);
				if (want.evicted_valid && want.evicted_page !== got.evicted_page)
					$display("%0t: evicted_page expected %0d actual %0d", $time,
						want.evicted_page, got.evicted_page);
				if (want.warm !== got.warm)
					$display("%0t: warm expected %0d actual %0d", $time, want.warm, got.warm);
				if (want.hit_count !== got.hit_count)
					$display("%0t: hit_count expected %0d actual %0d", $time,
						want.hit_count, got.hit_count);
				if (want.miss_count !== got.miss_count)
					$display("%0t: miss_count expected %0d actual %0d", $time,
						want.miss_count, got.miss_count);
				if (want.hit !== got.hit || want.slot !== got.slot
						|| want.evicted_valid !== got.evicted_valid
						|| (want.evicted_valid && want.evicted_page !== got.evicted_page)
						|| want.warm !== got.warm || want.hit_count !== got.hit_count
						|| want.miss_count !== got.miss_count)
					errors++;
			end
		end
	end

	task automatic send_page(logic [11:0] p);
		if (!no_idle && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		page_id <= p;
		do @(posedge clk); while (in_stall);
		pending_q.push_back(cache_lookup(p));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(lwc_reg_t idx, logic [6:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_CAPACITY) capacity = val;
		else dist_range = val[3:0];
	endtask

	function automatic logic [11:0] pick_page();
		if ($urandom_range(99) < 5) window_base = $urandom_range(NPAGE - 1);
		if ($urandom_range(99) < 12) return 12'($urandom_range(NPAGE - 1));
		return 12'((window_base + $urandom_range(48)) % NPAGE);
	endfunction

	task automatic run_random(int n);
		repeat (n) send_page(pick_page());
	endtask

	task automatic test_directed();
		send_page(12'd0);
		send_page(12'd4095);
		send_page(12'd0);
		send_page(12'd1);
		send_page(12'd4094);
		send_page(12'd4095);
		send_page(12'd2048);
		send_page(12'd2050);
		send_page(12'd2048);
		send_page(12'd1365);
		send_page(12'd2730);
		send_page(12'd1);
	endtask

	task automatic test_tiny_cache();
		write_reg(REG_CAPACITY, 7'd1);
		write_reg(REG_MAX_DIST, 7'd15);
		send_page(12'd100);
		send_page(12'd100);
		send_page(12'd101);
		send_page(12'd4000);
		write_reg(REG_CAPACITY, 7'd0);
		write_reg(REG_MAX_DIST, 7'd0);
		send_page(12'd7);
		send_page(12'd8);
		send_page(12'd8);
		run_random(60);
	endtask

	task automatic test_grow_shrink();
		write_reg(REG_CAPACITY, 7'd127);
		write_reg(REG_MAX_DIST, 7'd1);
		run_random(150);
		write_reg(REG_CAPACITY, 7'd5);
		write_reg(REG_MAX_DIST, 7'd7);
		run_random(120);
		write_reg(REG_CAPACITY, 7'd20);
		run_random(120);
	endtask

	task automatic test_steady_stream();
		write_reg(REG_CAPACITY, 7'd64);
		write_reg(REG_MAX_DIST, 7'd3);
		no_idle = 1'b1;
		run_random(250);
		no_idle = 1'b0;
		run_random(100);
	endtask

	task automatic test_random_settings();
		for (int i = 0; i < 6; i++) begin
			write_reg(REG_CAPACITY, 7'($urandom_range(1, 64)));
			write_reg(REG_MAX_DIST, 7'($urandom_range(1, 15)));
			run_random(60);
			drain();
			run_random(60);
		end
		write_reg(REG_CAPACITY, 7'd64);
		write_reg(REG_MAX_DIST, 7'd15);
		run_random(120);
	endtask

	initial begin
		foreach (resident[i]) resident[i] = 1'b0;
		foreach (slot_used[i]) begin
			slot_used[i] = 1'b0;
			slot_weight[i] = 0;
		end
		hand = 0;
		filled = 0;
		hits = 0;
		misses = 0;
		capacity = 7'(CAP_RESET);
		dist_range = 4'(MD_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tiny_cache();
		test_grow_shrink();
		test_steady_stream();
		test_random_settings();
		drain();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/lwc_pkg.sv
hw/rtl/lwc_ram.sv
hw/rtl/lwc_bitmap.sv
hw/rtl/locality_weighted_clock_cache_core.sv
tb/locality_weighted_clock_cache_core_test.sv
